// ----- rtl/sghg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash grid package
// Shared widths, command and register codes, hash primes and the types
// that pass between the hash pipeline and the bucket sequencer.
// ----------------------------------------------------------------------------
package sghg_pkg;

    localparam int POS_W    = 32;
    localparam int OFF_W    = 2;
    localparam int INV_W    = 24;
    localparam int LOG2_W   = 4;
    localparam int CFG_W    = 24;
    localparam int BUCKET_W = 10;
    localparam int SLOT_W   = 16;
    localparam int MEMBER_W = 13;
    localparam int CNT_W    = 16;
    localparam int HASH_W   = 16;
    localparam int CELL_W   = 24;

    localparam int MAX_CELLS_DEF     = 1024;
    localparam int CELL_CAPACITY_DEF = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [31:0] HASH_PRIME [3] = '{32'd73856093, 32'd19349663, 32'd83492791};

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam logic CFG_INV_CELL_SIZE   = 1'b0;
    localparam logic CFG_CELL_COUNT_LOG2 = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hval;
    } hash_res_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_FOLD,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_Q_EMIT,
        ST_CLEAR,
        ST_CLR_DONE
    } seq_state_t;

endpackage

// ----- rtl/sghg_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell hash pipeline
// Three lanes: floor(pos * inv / 2^32), add cell offset, multiply by prime,
// then XOR of the lanes masked to the bucket mask width.
// ----------------------------------------------------------------------------
module sghg_hash (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sghg_pkg::POS_W-1:0]  pos_x,
    input  logic signed [sghg_pkg::POS_W-1:0]  pos_y,
    input  logic signed [sghg_pkg::POS_W-1:0]  pos_z,
    input  logic signed [sghg_pkg::OFF_W-1:0]  off_x,
    input  logic signed [sghg_pkg::OFF_W-1:0]  off_y,
    input  logic signed [sghg_pkg::OFF_W-1:0]  off_z,
    input  logic        [sghg_pkg::INV_W-1:0]  inv_cell_size,
    input  logic        [sghg_pkg::LOG2_W-1:0] cell_count_log2,
    output sghg_pkg::hash_res_t                res
);
    import sghg_pkg::*;

    logic signed [POS_W-1:0]         pos_in [3];
    logic signed [OFF_W-1:0]         off_in [3];
    logic signed [INV_W:0]           inv_s;
    logic signed [POS_W+INV_W:0]     prod [3];
    logic signed [31:0]              cell_ext [3];
    logic [31:0]                     lane_h [3];
    logic [4:0]                      n_clamp;
    logic [HASH_W:0]                 mask_w;
    logic [31:0]                     h_all;

    logic signed [CELL_W-1:0]        cell1_reg [3];
    logic signed [OFF_W-1:0]         off1_reg [3];
    logic [31:0]                     lane2_reg [3];
    logic [HASH_W-1:0]               hval3_reg;
    logic                            v1_reg;
    logic                            v2_reg;
    logic                            v3_reg;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;
    assign off_in[0] = off_x;
    assign off_in[1] = off_y;
    assign off_in[2] = off_z;
    assign inv_s     = $signed({1'b0, inv_cell_size});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i]     = pos_in[i] * inv_s;
            cell_ext[i] = 32'(cell1_reg[i]) + 32'(off1_reg[i]);
            lane_h[i]   = 32'($unsigned(cell_ext[i]) * HASH_PRIME[i]);
        end
    end

    assign n_clamp = (cell_count_log2 > 4'd15) ? 5'd16 : {1'b0, cell_count_log2};
    assign mask_w  = (17'd1 << n_clamp) - 17'd1;
    assign h_all   = lane2_reg[0] ^ lane2_reg[1] ^ lane2_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cell1_reg[i] <= prod[i][POS_W+INV_W-1:32];
            off1_reg[i]  <= off_in[i];
            lane2_reg[i] <= lane_h[i];
        end
        hval3_reg <= h_all[HASH_W-1:0] & mask_w[HASH_W-1:0];
    end

    assign res.valid = v3_reg;
    assign res.hval  = hval3_reg;

endmodule

// ----- rtl/sghg_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket sequencer
// Holds the bucket count and entry memories, folds the hash into the table,
// runs insert read-modify-write, query entry walk and the clearing sweep.
// ----------------------------------------------------------------------------
module sghg_seq #(
    parameter int MAX_CELLS     = sghg_pkg::MAX_CELLS_DEF,
    parameter int CELL_CAPACITY = sghg_pkg::CELL_CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  sghg_pkg::cmd_t                      cmd,
    input  logic [sghg_pkg::MEMBER_W-1:0]       particle_id,
    input  sghg_pkg::hash_res_t                 hres,
    output logic                                ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sghg_pkg::BUCKET_W-1:0]       bucket,
    output logic [sghg_pkg::SLOT_W-1:0]         slot,
    output logic [sghg_pkg::MEMBER_W-1:0]       member,
    output logic                                stored,
    output logic                                found,
    output logic                                last
);
    import sghg_pkg::*;

    localparam int  BW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam bit  IS_POW2   = (MAX_CELLS & (MAX_CELLS - 1)) == 0;
    localparam int  ENT_DEPTH = MAX_CELLS * CELL_CAPACITY;
    localparam int  AW        = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int  KW        = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int  SW        = $clog2(CELL_CAPACITY + 1);

    // ceil(2^32 / MAX_CELLS): exact quotient for any 16-bit hash
    localparam logic [63:0] RECIP_W = ((64'd1 << 32) + 64'(MAX_CELLS) - 64'd1)
                                      / 64'(MAX_CELLS);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];

    logic [CNT_W-1:0]    cnt_mem [MAX_CELLS];
    logic [MEMBER_W-1:0] ent_mem [ENT_DEPTH];

    logic                cnt_we;
    logic [BW-1:0]       cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic                cnt_re;
    logic [BW-1:0]       cnt_raddr;
    logic [CNT_W-1:0]    cnt_rdata_reg;
    logic                ent_we;
    logic [AW-1:0]       ent_waddr;
    logic                ent_re;
    logic [AW-1:0]       ent_raddr;
    logic [MEMBER_W-1:0] ent_rdata_reg;

    seq_state_t          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [MEMBER_W-1:0] id_reg, id_next;
    logic [HASH_W-1:0]   rem_reg, rem_next;
    logic [HASH_W-1:0]   quo_reg, quo_next;
    logic [BW-1:0]       bucket_reg, bucket_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [BW-1:0]       idx_reg, idx_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [SW-1:0]       n_reg, n_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [BUCKET_W-1:0] out_bucket_reg, out_bucket_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [MEMBER_W-1:0] out_member_reg, out_member_next;
    logic                out_stored_reg, out_stored_next;
    logic                out_found_reg, out_found_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [47:0]         quo_prod;
    logic [31:0]         quo_mul;
    logic [HASH_W-1:0]   rem_fold;
    logic                keep;
    logic [SW-1:0]       n_cnt;
    logic                q_last;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= id_reg;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= ent_mem[ent_raddr];
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign quo_prod  = 48'(rem_reg) * 48'(RECIP);
    assign quo_mul   = 32'(quo_reg) * 32'(MAX_CELLS);
    assign rem_fold  = rem_reg - quo_mul[HASH_W-1:0];
    assign keep      = cnt_rdata_reg < CNT_W'(CELL_CAPACITY);
    assign n_cnt     = keep ? SW'(cnt_rdata_reg) : SW'(CELL_CAPACITY);
    assign q_last    = (SW'(k_reg) + SW'(1)) == n_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bucket_next     = bucket_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        ready           = 1'b0;
        cnt_we          = 1'b0;
        cnt_waddr       = bucket_reg;
        cnt_wdata       = '0;
        cnt_re          = 1'b0;
        cnt_raddr       = bucket_reg;
        ent_we          = 1'b0;
        ent_waddr       = base_reg + AW'(cnt_rdata_reg);
        ent_re          = 1'b0;
        ent_raddr       = base_reg;
        out_load        = 1'b0;
        out_bucket_next = BUCKET_W'(bucket_reg);
        out_slot_next   = '0;
        out_member_next = '0;
        out_stored_next = 1'b0;
        out_found_next  = 1'b0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = idx_reg;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == BW'(MAX_CELLS - 1))
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_CLR_DONE;
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    cmd_next = cmd;
                    id_next  = particle_id;
                    idx_next = '0;
                    case (cmd)
                        CMD_INSERT, CMD_QUERY: state_next = ST_HASH;
                        CMD_CLEAR:             state_next = ST_CLEAR;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hres.valid)
                begin
                    if (IS_POW2)
                    begin
                        bucket_next = hres.hval[BW-1:0];
                        state_next  = ST_CNT_RD;
                    end
                    else
                    begin
                        rem_next   = hres.hval;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                quo_next   = quo_prod[47:32];
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                bucket_next = rem_fold[BW-1:0];
                state_next  = ST_CNT_RD;
            end
            ST_CNT_RD:
            begin
                cnt_re     = 1'b1;
                base_next  = AW'(AW'(bucket_reg) * AW'(CELL_CAPACITY));
                state_next = ST_CNT_CHK;
            end
            ST_CNT_CHK:
            begin
                if (out_free)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        cnt_we          = 1'b1;
                        cnt_wdata       = (cnt_rdata_reg == CNT_MAX) ? cnt_rdata_reg
                                                                     : cnt_rdata_reg + 1'b1;
                        ent_we          = keep;
                        out_load        = 1'b1;
                        out_slot_next   = cnt_rdata_reg;
                        out_member_next = id_reg;
                        out_stored_next = keep;
                        state_next      = ST_IDLE;
                    end
                    else if (n_cnt == '0)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ent_re     = 1'b1;
                        k_next     = '0;
                        n_next     = n_cnt;
                        state_next = ST_Q_EMIT;
                    end
                end
            end
            ST_Q_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_slot_next   = SLOT_W'(k_reg);
                    out_member_next = ent_rdata_reg;
                    out_found_next  = 1'b1;
                    out_last_next   = q_last;
                    if (q_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ent_re    = 1'b1;
                        ent_raddr = base_reg + AW'(k_reg + 1'b1);
                        k_next    = k_reg + 1'b1;
                    end
                end
            end
            ST_CLR_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_bucket_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        bucket_reg <= bucket_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        if (out_load)
        begin
            out_bucket_reg <= out_bucket_next;
            out_slot_reg   <= out_slot_next;
            out_member_reg <= out_member_next;
            out_stored_reg <= out_stored_next;
            out_found_reg  <= out_found_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bucket    = out_bucket_reg;
    assign slot      = out_slot_reg;
    assign member    = out_member_reg;
    assign stored    = out_stored_reg;
    assign found     = out_found_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/spatial_hash_grid_bucketing_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash grid bucketing
// Insert, query and clear of a hashed particle grid.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   config  | cfg_we                 | cfg_index, cfg_data
//   in      | in_valid / in_ready    | cmd, pos_x/y/z, offset_x/y/z, particle_id
//   out     | out_valid / out_ready  | bucket, slot, member, stored, found, last
//
// Insert: accept, hash pipeline, count read, count write-back, then the result;
// a bucket fold follows the hash when MAX_CELLS is not a power of two.
// Query: hash and count read, then one result per cycle while not stalled.
// Clear: count sweep of all MAX_CELLS buckets, one per cycle, then the item.
// After reset the same sweep runs with in_ready low.
// A stalled output holds the sequencer; one item is in flight at a time.
// ----------------------------------------------------------------------------
module spatial_hash_grid_bucketing_top #(
    parameter int MAX_CELLS     = sghg_pkg::MAX_CELLS_DEF,
    parameter int CELL_CAPACITY = sghg_pkg::CELL_CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sghg_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic signed [sghg_pkg::POS_W-1:0]   pos_x,
    input  logic signed [sghg_pkg::POS_W-1:0]   pos_y,
    input  logic signed [sghg_pkg::POS_W-1:0]   pos_z,
    input  logic signed [sghg_pkg::OFF_W-1:0]   offset_x,
    input  logic signed [sghg_pkg::OFF_W-1:0]   offset_y,
    input  logic signed [sghg_pkg::OFF_W-1:0]   offset_z,
    input  logic [sghg_pkg::MEMBER_W-1:0]       particle_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sghg_pkg::BUCKET_W-1:0]       bucket,
    output logic [sghg_pkg::SLOT_W-1:0]         slot,
    output logic [sghg_pkg::MEMBER_W-1:0]       member,
    output logic                                stored,
    output logic                                found,
    output logic                                last
);
    import sghg_pkg::*;

    logic [INV_W-1:0]        inv_reg;
    logic [LOG2_W-1:0]       log2_reg;
    logic                    accept;
    logic                    hash_start;
    logic                    is_query;
    cmd_t                    cmd_in;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
    hash_res_t               hres;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg  <= INV_W'(65536);
            log2_reg <= LOG2_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INV_CELL_SIZE:   inv_reg  <= cfg_data[INV_W-1:0];
                CFG_CELL_COUNT_LOG2: log2_reg <= cfg_data[LOG2_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cmd_in     = cmd_t'(cmd);
    assign accept     = in_valid && in_ready;
    assign is_query   = (cmd_in == CMD_QUERY);
    assign hash_start = accept && ((cmd_in == CMD_INSERT) || is_query);
    assign off_x      = is_query ? offset_x : '0;
    assign off_y      = is_query ? offset_y : '0;
    assign off_z      = is_query ? offset_z : '0;

    sghg_hash u_hash (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (hash_start),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .off_x           (off_x),
        .off_y           (off_y),
        .off_z           (off_z),
        .inv_cell_size   (inv_reg),
        .cell_count_log2 (log2_reg),
        .res             (hres)
    );

    sghg_seq #(
        .MAX_CELLS     (MAX_CELLS),
        .CELL_CAPACITY (CELL_CAPACITY)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .cmd         (cmd_in),
        .particle_id (particle_id),
        .hres        (hres),
        .ready       (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bucket      (bucket),
        .slot        (slot),
        .member      (member),
        .stored      (stored),
        .found       (found),
        .last        (last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_in == CMD_INSERT || cmd_in == CMD_QUERY || cmd_in == CMD_CLEAR))
        |=> !in_ready)
        else $error("block still ready after taking a command item");

    a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (!stored && slot < SLOT_W'(CELL_CAPACITY)))
        else $error("query item beyond bucket capacity or marked stored");

    a_stored_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stored) |-> (last && slot < SLOT_W'(CELL_CAPACITY)))
        else $error("stored insert item with slot at or past capacity");

    a_hash_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        hres.valid |-> !in_ready)
        else $error("hash result while the sequencer is idle");

endmodule
